// ===== rtl/hss_pkg.sv =====
// shared types, constants and helpers for the horspool substring search block
package hss_pkg;

    localparam int POS_W       = 32;
    localparam int LEN_W       = 5;
    localparam int BYTE_W      = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int PAT_BYTES   = 16;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_LOW    = 2'd0,
        CFG_PATTERN_HIGH   = 2'd1,
        CFG_PATTERN_LENGTH = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        ST_IDLE,
        ST_COMPARE
    } state_t;

    function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                                 input logic [LEN_W-1:0] b);
        logic [POS_W:0] sum;
        sum = {1'b0, a} + {{(POS_W + 1 - LEN_W){1'b0}}, b};
        return sum[POS_W] ? POS_MAX : sum[POS_W-1:0];
    endfunction

endpackage

// ===== rtl/hss_cell.sv =====
// one window cell: holds a text byte, passes it on and compares it with its pattern byte
module hss_cell (
    input  logic                      clk,
    input  logic                      shift_en,
    input  logic [hss_pkg::BYTE_W-1:0] din,
    input  logic [hss_pkg::BYTE_W-1:0] pattern_byte,
    output logic [hss_pkg::BYTE_W-1:0] dout,
    output logic                      hit
);
    import hss_pkg::*;

    logic [BYTE_W-1:0] byte_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            byte_reg <= din;
        end
    end

    assign dout = byte_reg;
    assign hit  = (byte_reg == pattern_byte);

endmodule

// ===== rtl/horspool_substring_search.sv =====
// top level of the horspool substring search block
// Text bytes enter a chain of window cells, newest byte in cell 0. A byte that
// does not complete an alignment is taken and gives no result. A byte that
// completes an alignment starts a right-to-left compare of the pattern
// against the window: every cell checks its byte against its pattern byte at
// once, and a compare counter then emits one compared position per cycle,
// unless the output stalls, through the output register, from 1 up to
// pattern length positions (at most 16), ending at the first mismatch or a
// full match. The input is held off while a compare runs, including any
// output stall; the next byte is taken while the final result still waits.
// The shift to the next alignment comes from the newest byte and the pattern,
// and positions saturate at the top of the 32-bit range. Pattern registers may
// be written only while no compare is running.
module horspool_substring_search #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // text_byte
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [31:0]                     m_axis_tdata,   // compared_position
    output logic                            m_axis_tlast,   // last_of_run
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hss_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hss_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import hss_pkg::*;

    localparam int LenCap = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;
    localparam int KW     = (LenCap > 1) ? $clog2(LenCap) : 1;
    localparam logic [LEN_W-1:0] LenCapV = LEN_W'(LenCap);

    // configuration
    logic [CFG_DATA_W-1:0] pat_low_reg;
    logic [CFG_DATA_W-1:0] pat_high_reg;
    logic [LEN_W-1:0]      pat_len_reg;

    // control state
    state_t            state_reg, state_next;
    logic [KW-1:0]     k_reg, k_next;
    logic [LEN_W-1:0]  filled_reg, filled_next;
    logic [LEN_W-1:0]  until_reg, until_next;
    logic [POS_W-1:0]  start_reg, start_next;

    // output stage
    logic              out_valid_reg, out_valid_next;
    logic [POS_W-1:0]  out_pos_reg, out_pos_next;
    logic              out_last_reg, out_last_next;

    logic                      in_acc;
    logic                      load;
    logic                      res_last;
    logic [LEN_W-1:0]          len_eff;
    logic [LEN_W-1:0]          offset;
    logic [LEN_W-1:0]          shift;
    logic [2*CFG_DATA_W-1:0]   pattern;
    logic [BYTE_W-1:0]         chain [LenCap+1];
    logic [LenCap-1:0]         hit;

    assign pattern = {pat_high_reg, pat_low_reg};
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= LEN_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PATTERN_LOW:    pat_low_reg  <= cfg_data;
                CFG_PATTERN_HIGH:   pat_high_reg <= cfg_data;
                CFG_PATTERN_LENGTH: pat_len_reg  <= cfg_data[LEN_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        if (pat_len_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (pat_len_reg > LenCapV)
        begin
            len_eff = LenCapV;
        end
        else
        begin
            len_eff = pat_len_reg;
        end
    end

    // window chain
    assign chain[0] = s_axis_tdata;

    for (genvar c = 0; c < LenCap; c++)
    begin : g_cell
        logic [LEN_W-1:0] pidx;
        assign pidx = len_eff - LEN_W'(1) - LEN_W'(c);

        hss_cell u_cell (
            .clk          (clk),
            .shift_en     (in_acc),
            .din          (chain[c]),
            .pattern_byte (pattern[pidx[3:0]*BYTE_W +: BYTE_W]),
            .dout         (chain[c+1]),
            .hit          (hit[c])
        );
    end

    // horspool shift from the newest byte
    always_comb
    begin
        shift = len_eff;
        for (int j = 0; j < PAT_BYTES - 1; j++)
        begin
            if ((LEN_W'(j + 1) < len_eff) && (pattern[j*BYTE_W +: BYTE_W] == chain[1]))
            begin
                shift = len_eff - LEN_W'(1) - LEN_W'(j);
            end
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign load          = (state_reg == ST_COMPARE) && (!out_valid_reg || m_axis_tready);
    assign offset        = len_eff - LEN_W'(1) - LEN_W'(k_reg);
    assign res_last      = !hit[k_reg] || (LEN_W'(k_reg) == len_eff - LEN_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            filled_reg    <= '0;
            until_reg     <= '0;
            start_reg     <= POS_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            filled_reg    <= filled_next;
            until_reg     <= until_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_pos_reg  <= out_pos_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        filled_next    = filled_reg;
        until_next     = until_reg;
        start_next     = start_reg;
        out_valid_next = out_valid_reg;
        out_pos_next   = out_pos_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (filled_reg < len_eff)
                    begin
                        filled_next = filled_reg + LEN_W'(1);
                        if (filled_reg + LEN_W'(1) == len_eff)
                        begin
                            state_next = ST_COMPARE;
                            k_next     = '0;
                        end
                    end
                    else if (until_reg <= LEN_W'(1))
                    begin
                        state_next = ST_COMPARE;
                        k_next     = '0;
                    end
                    else
                    begin
                        until_next = until_reg - LEN_W'(1);
                    end
                end
            end
            ST_COMPARE:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    out_pos_next   = sat_add(start_reg, offset);
                    out_last_next  = res_last;
                    if (res_last)
                    begin
                        state_next = ST_IDLE;
                        start_next = sat_add(start_reg, shift);
                        until_next = shift;
                    end
                    else
                    begin
                        k_next = k_reg + KW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pos_reg;
    assign m_axis_tlast  = out_last_reg;

    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMPARE) |-> (LEN_W'(k_reg) < len_eff))
        else $error("compare index beyond pattern length");

    a_filled_capped: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= LenCapV)
        else $error("fill count beyond window depth");

    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (load && res_last) |=> (state_reg == ST_IDLE) && out_valid_reg && out_last_reg)
        else $error("final compare did not close the run");

    a_start_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMPARE) |=> (start_reg >= $past(start_reg)))
        else $error("window start moved backward");

endmodule
